[src/mmts_pkg.sv]
// ----------------------------------------------------------------------------
// Multi-mode task scheduler package
// Shared types and codes for the scheduler's sequencer, table and top level.
// ----------------------------------------------------------------------------
package mmts_pkg;

  // Entry states
  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_RUN     = 2'd1;
  localparam logic [1:0] ST_ZOMBIE  = 2'd2;
  localparam logic [1:0] ST_BLOCKED = 2'd3;

  // Scheduling modes
  localparam logic [2:0] MODE_RR    = 3'd0;
  localparam logic [2:0] MODE_LOW   = 3'd1;
  localparam logic [2:0] MODE_PRIO  = 3'd2;
  localparam logic [2:0] MODE_SHARE = 3'd3;
  localparam logic [2:0] MODE_QUEUE = 3'd4;

  // Event opcodes
  localparam logic [2:0] OP_YIELD     = 3'd0;
  localparam logic [2:0] OP_EXIT      = 3'd1;
  localparam logic [2:0] OP_SET_PRIO  = 3'd2;
  localparam logic [2:0] OP_SET_SHARE = 3'd3;
  localparam logic [2:0] OP_SET_QUEUE = 3'd4;
  localparam logic [2:0] OP_TICK      = 3'd5;

  // Error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_NORUN = 2'd1;
  localparam logic [1:0] ERR_QUEUE = 2'd2;

  localparam logic [7:0] SHARE_MAX = 8'd255;
  localparam logic [1:0] QUEUE_MAX = 2'd3;

  typedef struct packed {
    logic [1:0]  state;
    logic [15:0] priority_v;
    logic [7:0]  share;
    logic [7:0]  share_count;
    logic [1:0]  queue;
  } entry_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] argument;
  } in_item_t;

  typedef struct packed {
    logic [2:0] grant_id;
    logic       halted;
    logic [1:0] error_code;
  } out_item_t;

endpackage

[src/mmts_table.sv]
// ----------------------------------------------------------------------------
// Scheduler entry table
// One synchronous memory of entries, one write and one registered read port.
// ----------------------------------------------------------------------------
module mmts_table #(
  parameter int NUM_ENTRIES = 5
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [$clog2(NUM_ENTRIES)-1:0] rd_addr,
  output mmts_pkg::entry_t               rd_data,
  input  logic                           wr_en,
  input  logic [$clog2(NUM_ENTRIES)-1:0] wr_addr,
  input  mmts_pkg::entry_t               wr_data
);
  import mmts_pkg::*;

  entry_t mem_r [NUM_ENTRIES];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/mmts_seq.sv]
// ----------------------------------------------------------------------------
// Scheduler sequencer
// Walks the entry table one entry at a time, a read state then an evaluate
// state per entry, for every scheduling pass.
module mmts_seq #(
  parameter int NUM_ENTRIES = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [2:0]                     mode_i,
  input  logic                           start_i,
  input  mmts_pkg::in_item_t             item_i,
  output logic                           idle_o,
  output logic                           done_o,
  output mmts_pkg::out_item_t            result_o,
  input  logic                           ack_i,
  output logic                           rd_en,
  output logic [$clog2(NUM_ENTRIES)-1:0] rd_addr,
  input  mmts_pkg::entry_t               rd_data,
  output logic                           wr_en,
  output logic [$clog2(NUM_ENTRIES)-1:0] wr_addr,
  output mmts_pkg::entry_t               wr_data
);
  import mmts_pkg::*;

  localparam int IW = $clog2(NUM_ENTRIES);
  localparam int KW = $clog2(2 * NUM_ENTRIES + 1);

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_MOD  = 6'b000100,
    S_RD   = 6'b001000,
    S_EV   = 6'b010000,
    S_OUT  = 6'b100000
  } fsm_t;

  typedef enum logic [7:0] {
    PH_RR    = 8'b00000001,
    PH_LOW   = 8'b00000010,
    PH_PMIN  = 8'b00000100,
    PH_PSEL  = 8'b00001000,
    PH_SHARE = 8'b00010000,
    PH_QFIND = 8'b00100000,
    PH_QMIN  = 8'b01000000,
    PH_QBLK  = 8'b10000000
  } phase_t;

  fsm_t          fsm_r, fsm_nxt;
  phase_t        phase_r, phase_nxt;
  logic [IW-1:0] p_r, p_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic          halt_r, halt_nxt;
  logic [1:0]    err_r, err_nxt;
  logic [15:0]   best_r, best_nxt;
  logic          any_r, any_nxt;
  logic [1:0]    low_r, low_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [15:0]   arg_r, arg_nxt;
  logic [IW-1:0] init_r, init_nxt;

  phase_t        go_phase;
  logic [IW-1:0] go_p;
  logic [KW-1:0] go_k;
  logic          last;
  logic          any_n;
  logic [15:0]   best_n;
  logic [1:0]    st_n;
  logic [1:0]    low_n;
  entry_t        mod_e;
  entry_t        init_e;

  function automatic logic [IW-1:0] nxt_idx(input logic [IW-1:0] v);
    nxt_idx = (v == IW'(NUM_ENTRIES - 1)) ? '0 : v + 1'b1;
  endfunction

  // Where each mode's first walk starts.
  always_comb begin
    case (mode_i)
      MODE_LOW: begin
        go_phase = PH_LOW;
        go_p     = IW'(1);
        go_k     = KW'(NUM_ENTRIES - 1);
      end
      MODE_PRIO: begin
        go_phase = PH_PMIN;
        go_p     = IW'(1);
        go_k     = KW'(NUM_ENTRIES - 1);
      end
      MODE_SHARE: begin
        go_phase = PH_SHARE;
        go_p     = cur_r;
        go_k     = KW'(2 * NUM_ENTRIES);
      end
      MODE_QUEUE: begin
        go_phase = PH_QFIND;
        go_p     = cur_r;
        go_k     = KW'(NUM_ENTRIES);
      end
      default: begin
        go_phase = PH_RR;
        go_p     = nxt_idx(cur_r);
        go_k     = KW'(NUM_ENTRIES);
      end
    endcase
  end

  assign last = (k_r == KW'(1));

  always_comb begin
    any_n  = any_r;
    best_n = best_r;
    if (rd_data.state == ST_RUN && (!any_r || rd_data.priority_v < best_r)) begin
      any_n  = 1'b1;
      best_n = rd_data.priority_v;
    end
    st_n  = (rd_data.state == ST_BLOCKED) ? ST_RUN : rd_data.state;
    low_n = low_r;
    if (st_n == ST_RUN && rd_data.queue < low_r) begin
      low_n = rd_data.queue;
    end
  end

  always_comb begin
    mod_e = rd_data;
    case (op_r)
      OP_EXIT:      mod_e.state = ST_ZOMBIE;
      OP_SET_PRIO:  mod_e.priority_v = arg_r;
      OP_SET_SHARE: mod_e.share = (arg_r > 16'(SHARE_MAX)) ? SHARE_MAX : arg_r[7:0];
      OP_SET_QUEUE: mod_e.queue = (arg_r > 16'(QUEUE_MAX)) ? QUEUE_MAX : arg_r[1:0];
      default:      mod_e = rd_data;
    endcase
  end

  always_comb begin
    init_e             = '0;
    init_e.state       = (init_r == '0) ? ST_EMPTY : ST_RUN;
    init_e.share_count = (init_r == IW'(1)) ? 8'd1 : 8'd0;
    init_e.queue       = (init_r == '0) ? 2'd0 : {1'b0, ~init_r[0]};
  end

  always_comb begin
    fsm_nxt   = fsm_r;
    phase_nxt = phase_r;
    p_nxt     = p_r;
    k_nxt     = k_r;
    cur_nxt   = cur_r;
    halt_nxt  = halt_r;
    err_nxt   = err_r;
    best_nxt  = best_r;
    any_nxt   = any_r;
    low_nxt   = low_r;
    op_nxt    = op_r;
    arg_nxt   = arg_r;
    init_nxt  = init_r;
    rd_en     = 1'b0;
    rd_addr   = p_r;
    wr_en     = 1'b0;
    wr_addr   = p_r;
    wr_data   = rd_data;

    case (fsm_r)
      S_INIT: begin
        wr_en    = 1'b1;
        wr_addr  = init_r;
        wr_data  = init_e;
        init_nxt = nxt_idx(init_r);
        if (init_r == IW'(NUM_ENTRIES - 1)) begin
          fsm_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start_i) begin
          op_nxt  = item_i.opcode;
          arg_nxt = item_i.argument;
          if (halt_r) begin
            fsm_nxt = S_OUT;
          end else begin
            case (item_i.opcode)
              OP_YIELD, OP_TICK: begin
                phase_nxt = go_phase;
                p_nxt     = go_p;
                k_nxt     = go_k;
                any_nxt   = 1'b0;
                fsm_nxt   = S_RD;
              end
              OP_EXIT, OP_SET_PRIO, OP_SET_SHARE, OP_SET_QUEUE: begin
                rd_en   = 1'b1;
                rd_addr = cur_r;
                fsm_nxt = S_MOD;
              end
              default: fsm_nxt = S_OUT;
            endcase
          end
        end
      end

      S_MOD: begin
        wr_en   = 1'b1;
        wr_addr = cur_r;
        wr_data = mod_e;
        if (op_r == OP_EXIT) begin
          phase_nxt = go_phase;
          p_nxt     = go_p;
          k_nxt     = go_k;
          any_nxt   = 1'b0;
          fsm_nxt   = S_RD;
        end else begin
          fsm_nxt = S_OUT;
        end
      end

      S_RD: begin
        rd_en   = 1'b1;
        rd_addr = p_r;
        fsm_nxt = S_EV;
      end

      S_EV: begin
        // Default: move to the next entry of this walk.
        fsm_nxt = S_RD;
        p_nxt   = nxt_idx(p_r);
        k_nxt   = k_r - 1'b1;
        case (phase_r)
          PH_RR, PH_LOW: begin
            if (rd_data.state == ST_RUN) begin
              cur_nxt = p_r;
              fsm_nxt = S_OUT;
            end else if (last) begin
              halt_nxt = 1'b1;
              err_nxt  = ERR_NORUN;
              fsm_nxt  = S_OUT;
            end
          end
          PH_PMIN: begin
            any_nxt  = any_n;
            best_nxt = best_n;
            if (last) begin
              if (!any_n) begin
                halt_nxt = 1'b1;
                err_nxt  = ERR_NORUN;
                fsm_nxt  = S_OUT;
              end else begin
                phase_nxt = PH_PSEL;
                p_nxt     = nxt_idx(cur_r);
                k_nxt     = KW'(NUM_ENTRIES);
              end
            end
          end
          PH_PSEL: begin
            if (rd_data.state == ST_RUN && rd_data.priority_v <= best_r) begin
              cur_nxt = p_r;
              fsm_nxt = S_OUT;
            end else if (last) begin
              halt_nxt = 1'b1;
              err_nxt  = ERR_NORUN;
              fsm_nxt  = S_OUT;
            end
          end
          PH_SHARE: begin
            if (rd_data.state == ST_RUN) begin
              wr_en = 1'b1;
              if (rd_data.share_count >= rd_data.share) begin
                wr_data.share_count = 8'd0;
              end else begin
                wr_data.share_count = rd_data.share_count + 8'd1;
                cur_nxt = p_r;
                fsm_nxt = S_OUT;
              end
            end
            if (fsm_nxt != S_OUT && last) begin
              halt_nxt = 1'b1;
              err_nxt  = ERR_NORUN;
              fsm_nxt  = S_OUT;
            end
          end
          PH_QFIND: begin
            if (rd_data.state == ST_RUN || rd_data.state == ST_BLOCKED) begin
              low_nxt   = rd_data.queue;
              phase_nxt = PH_QMIN;
              p_nxt     = IW'(1);
              k_nxt     = KW'(NUM_ENTRIES - 1);
            end else if (last) begin
              halt_nxt = 1'b1;
              err_nxt  = ERR_NORUN;
              fsm_nxt  = S_OUT;
            end
          end
          PH_QMIN: begin
            if (rd_data.state == ST_BLOCKED) begin
              wr_en         = 1'b1;
              wr_data.state = ST_RUN;
            end
            low_nxt = low_n;
            if (last) begin
              phase_nxt = PH_QBLK;
              p_nxt     = IW'(1);
              k_nxt     = KW'(NUM_ENTRIES - 1);
            end
          end
          PH_QBLK: begin
            if (rd_data.state == ST_RUN && rd_data.queue != low_r) begin
              wr_en         = 1'b1;
              wr_data.state = ST_BLOCKED;
            end
            if (last) begin
              if (low_r > 2'd1) begin
                halt_nxt = 1'b1;
                err_nxt  = ERR_QUEUE;
                fsm_nxt  = S_OUT;
              end else if (low_r == 2'd0) begin
                phase_nxt = PH_RR;
                p_nxt     = nxt_idx(cur_r);
                k_nxt     = KW'(NUM_ENTRIES);
              end else begin
                phase_nxt = PH_LOW;
                p_nxt     = IW'(1);
                k_nxt     = KW'(NUM_ENTRIES - 1);
              end
            end
          end
          default: fsm_nxt = S_OUT;
        endcase
      end

      S_OUT: begin
        if (ack_i) begin
          fsm_nxt = S_IDLE;
        end
      end

      default: fsm_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r   <= S_INIT;
      phase_r <= PH_RR;
      cur_r   <= IW'(1);
      halt_r  <= 1'b0;
      err_r   <= ERR_NONE;
      init_r  <= '0;
    end else begin
      fsm_r   <= fsm_nxt;
      phase_r <= phase_nxt;
      cur_r   <= cur_nxt;
      halt_r  <= halt_nxt;
      err_r   <= err_nxt;
      init_r  <= init_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    k_r    <= k_nxt;
    best_r <= best_nxt;
    any_r  <= any_nxt;
    low_r  <= low_nxt;
    op_r   <= op_nxt;
    arg_r  <= arg_nxt;
  end

  assign idle_o              = (fsm_r == S_IDLE);
  assign done_o              = (fsm_r == S_OUT);
  assign result_o.grant_id   = 3'(cur_r);
  assign result_o.halted     = halt_r;
  assign result_o.error_code = halt_r ? err_r : ERR_NONE;

endmodule

[src/multi_mode_task_scheduler.sv]
// ----------------------------------------------------------------------------
// Multi-mode task scheduler
// Picks the next entry to run under one of five modes from a table in memory.
// ----------------------------------------------------------------------------
// Set events pass through S_MOD to S_OUT and unknown events go straight to S_OUT;
// a scheduling event passes S_RD and S_EV for each table entry the sequencer visits.
// One event is in flight at a time; the output register lets the next one in.
// While the table is written with its reset values after reset, no event is accepted.
module multi_mode_task_scheduler #(
  parameter int NUM_ENTRIES = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mmts_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mmts_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_data
);
  import mmts_pkg::*;

  localparam int IW = $clog2(NUM_ENTRIES);

  logic [2:0]    sched_mode_r;
  logic          seq_idle;
  logic          seq_done;
  logic          seq_ack;
  out_item_t     seq_result;
  logic          out_valid_r;
  out_item_t     out_data_r;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sched_mode_r <= MODE_RR;
    end else if (cfg_valid) begin
      sched_mode_r <= cfg_data;
    end
  end

  mmts_table #(.NUM_ENTRIES(NUM_ENTRIES)) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  mmts_seq #(.NUM_ENTRIES(NUM_ENTRIES)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode_i   (sched_mode_r),
    .start_i  (in_valid),
    .item_i   (in_data),
    .idle_o   (seq_idle),
    .done_o   (seq_done),
    .result_o (seq_result),
    .ack_i    (seq_ack),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  assign in_ready = seq_idle;
  // A finished result moves into the output register when it is free.
  assign seq_ack  = seq_done & (~out_valid_r | out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_ack) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_ack) begin
      out_data_r <= seq_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer still idle after an accepted beat");

  a_halt_has_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.halted) |-> (out_data.error_code != ERR_NONE))
    else $error("halted result without an error code");

  a_running_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.halted) |-> (out_data.error_code == ERR_NONE))
    else $error("error code reported while running");

  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_done && out_valid && !out_ready) |=> seq_done)
    else $error("result lost while the output register was full");

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// Multi-mode task scheduler testbench
// Drives scheduling events through every mode and register setting, predicts
// each grant beat from a local copy of the entry table and compares it field
// by field, finishing with a deliberate halt and a check that it sticks.
// ----------------------------------------------------------------------------
module tb;
  import mmts_pkg::*;

  localparam int         N          = 5;
  localparam int         IDLE_LIMIT = 4000;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam logic [2:0] MODE_TOP   = 3'd7;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [2:0] cfg_data = '0;

  // Local copy of the scheduler state
  logic [1:0]  ent_state [N];
  logic [15:0] ent_prio  [N];
  logic [7:0]  ent_share [N];
  logic [7:0]  ent_runs  [N];
  logic [1:0]  ent_queue [N];
  int          cur_id;
  bit          halt_m;
  logic [1:0]  halt_code;
  logic [2:0]  mode_m;

  out_item_t grant_expect_q[$];
  int  n_events = 0, n_grants = 0, n_errors = 0, n_cfg = 0, idle_cycles = 0;
  bit  quiet, halt_phase;

  multi_mode_task_scheduler #(.NUM_ENTRIES(N)) u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_data
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= 29);
  end

  // ---- predictor ----------------------------------------------------------
  function automatic int next_rr(int from);
    int p;
    for (int k = 1; k <= N; k++) begin
      p = (from + k) % N;
      if (ent_state[p] == ST_RUN) return p;
    end
    return -1;
  endfunction

  function automatic int next_low();
    for (int p = 1; p < N; p++)
      if (ent_state[p] == ST_RUN) return p;
    return -1;
  endfunction

  function automatic int next_prio(int from);
    bit          any;
    logic [15:0] best;
    int          p;
    any = 0;
    best = '0;
    for (int i = 1; i < N; i++)
      if (ent_state[i] == ST_RUN && (!any || ent_prio[i] < best)) begin
        best = ent_prio[i];
        any = 1;
      end
    if (!any) return -1;
    for (int k = 1; k <= N; k++) begin
      p = (from + k) % N;
      if (ent_state[p] == ST_RUN && ent_prio[p] <= best) return p;
    end
    return -1;
  endfunction

  function automatic int next_share(int from);
    int p;
    p = from % N;
    for (int k = 0; k < 2 * N; k++) begin
      if (ent_state[p] == ST_RUN) begin
        if (ent_runs[p] >= ent_share[p]) begin
          ent_runs[p] = '0;
        end else begin
          ent_runs[p] = ent_runs[p] + 8'd1;
          return p;
        end
      end
      p = (p + 1) % N;
    end
    return -1;
  endfunction

  function automatic int next_queue(int from, output logic [1:0] e);
    int         p, r;
    bit         found;
    logic [1:0] low;
    e = ERR_NORUN;
    found = 0;
    p = from % N;
    for (int k = 0; k < N; k++) begin
      if (ent_state[p] != ST_ZOMBIE && ent_state[p] != ST_EMPTY) begin
        found = 1;
        break;
      end
      p = (p + 1) % N;
    end
    if (!found) return -1;
    low = ent_queue[p];
    // Blocked entries are woken first, then everything off the lowest level
    // is parked again.
    for (int i = 1; i < N; i++) begin
      if (ent_state[i] == ST_BLOCKED) ent_state[i] = ST_RUN;
      if (ent_state[i] == ST_RUN && ent_queue[i] < low) low = ent_queue[i];
    end
    for (int i = 1; i < N; i++)
      if (ent_state[i] == ST_RUN && ent_queue[i] != low) ent_state[i] = ST_BLOCKED;
    if (low > 2'd1) begin
      e = ERR_QUEUE;
      return -1;
    end
    r = (low == 2'd0) ? next_rr(from) : next_low();
    return r;
  endfunction

  function automatic void pick_next();
    logic [1:0] e;
    int         r;
    e = ERR_NORUN;
    case (mode_m)
      MODE_LOW:   r = next_low();
      MODE_PRIO:  r = next_prio(cur_id);
      MODE_SHARE: r = next_share(cur_id);
      MODE_QUEUE: r = next_queue(cur_id, e);
      default:    r = next_rr(cur_id);
    endcase
    if (r < 0) begin
      halt_m = 1;
      halt_code = e;
    end else begin
      cur_id = r;
    end
  endfunction

  function automatic out_item_t predict_grant(in_item_t it);
    out_item_t o;
    int        c;
    c = cur_id % N;
    if (!halt_m) begin
      case (it.opcode)
        OP_YIELD, OP_TICK: pick_next();
        OP_EXIT: begin
          ent_state[c] = ST_ZOMBIE;
          pick_next();
        end
        OP_SET_PRIO:  ent_prio[c] = it.argument;
        OP_SET_SHARE: ent_share[c] = (it.argument > 16'd255) ? SHARE_MAX : it.argument[7:0];
        OP_SET_QUEUE: ent_queue[c] = (it.argument > 16'd3) ? QUEUE_MAX : it.argument[1:0];
        default: ;
      endcase
    end
    o.grant_id   = cur_id[2:0];
    o.halted     = halt_m;
    o.error_code = halt_m ? halt_code : ERR_NONE;
    return o;
  endfunction

  // Trial step on a saved copy: tells whether an event would stop the block.
  function automatic bit would_halt(in_item_t it);
    logic [1:0]  s_state [N];
    logic [7:0]  s_runs  [N];
    logic [15:0] s_prio  [N];
    logic [7:0]  s_share [N];
    logic [1:0]  s_queue [N];
    int          s_cur;
    out_item_t   o;
    s_state = ent_state; s_runs = ent_runs; s_prio = ent_prio;
    s_share = ent_share; s_queue = ent_queue; s_cur = cur_id;
    o = predict_grant(it);
    ent_state = s_state; ent_runs = s_runs; ent_prio = s_prio;
    ent_share = s_share; ent_queue = s_queue; cur_id = s_cur;
    halt_m = 0;
    return o.halted;
  endfunction

  function automatic int live_entries();
    int n;
    n = 0;
    for (int i = 1; i < N; i++)
      if (ent_state[i] == ST_RUN || ent_state[i] == ST_BLOCKED) n++;
    return n;
  endfunction

  // ---- stimulus -----------------------------------------------------------
  task automatic send_event(logic [2:0] op, logic [15:0] arg);
    in_item_t  it;
    out_item_t exp_r;
    it.opcode = op;
    it.argument = arg;
    // Outside the halt test an event that would stop the block is swapped
    // for a spare opcode, which the block must simply ignore.
    if (!halt_phase && would_halt(it)) it.opcode = OP_SPARE_A;
    if (!quiet && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    exp_r = predict_grant(it);
    grant_expect_q.push_back(exp_r);
    n_events++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (grant_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(logic [2:0] m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_m = m;
    n_cfg++;
  endtask

  // ---- tests --------------------------------------------------------------
  task automatic test_field_extremes();
    send_event(OP_YIELD, 16'h0000);
    send_event(OP_SET_PRIO, 16'hFFFF);
    send_event(OP_SET_PRIO, 16'h0000);
    send_event(OP_SET_SHARE, 16'd255);
    send_event(OP_SET_SHARE, 16'd256);
    send_event(OP_SET_SHARE, 16'hFFFF);
    send_event(OP_SET_QUEUE, 16'd4);
    send_event(OP_SET_QUEUE, 16'hFFFF);
    send_event(OP_SET_QUEUE, 16'd0);
    send_event(OP_SPARE_A, 16'hA5A5);
    send_event(OP_SPARE_B, 16'h5A5A);
    send_event(OP_TICK, 16'h0000);
  endtask

  task automatic test_each_mode();
    // Give every running entry a share so that proportional mode can run at all.
    for (int i = 0; i < N - 1; i++) begin
      send_event(OP_SET_SHARE, 16'($urandom_range(1, 3)));
      send_event(OP_YIELD, 16'h0);
    end
    for (int m = 1; m <= 7; m++) begin
      write_mode(3'(m));
      send_event(OP_YIELD, 16'h0);
      send_event(OP_TICK, 16'h0);
    end
    write_mode(MODE_RR);
    send_event(OP_EXIT, 16'h0);
  endtask

  task automatic test_random(int total);
    int r, done;
    logic [15:0] a;
    logic [2:0]  op;
    done = 0;
    while (done < total) begin
      write_mode(3'($urandom_range(0, 7)));
      // The first block always runs with no idling on either side.
      quiet = (done == 0) || ($urandom_range(0, 5) == 0);
      for (int i = 0; i < 150 && done < total; i++) begin
        r = $urandom_range(0, 99);
        a = 16'($urandom_range(0, 65535));
        if (r < 35)      op = OP_YIELD;
        else if (r < 50) op = OP_TICK;
        else if (r < 58) op = OP_SET_PRIO;
        else if (r < 68) begin
          op = OP_SET_SHARE;
          if ($urandom_range(0, 9) != 0) a = 16'($urandom_range(0, 6));
        end else if (r < 78) begin
          op = OP_SET_QUEUE;
          if ($urandom_range(0, 9) != 0) a = 16'($urandom_range(0, 1));
        end else if (r < 81) op = (live_entries() > 2) ? OP_EXIT : OP_YIELD;
        else if (r < 84) op = ($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B;
        else op = 3'($urandom_range(0, 5));
        if (op == OP_EXIT && live_entries() <= 2) op = OP_TICK;
        send_event(op, a);
        done++;
      end
      quiet = 0;
    end
  endtask

  task automatic test_halt();
    halt_phase = 1;
    if ($urandom_range(0, 1) != 0) begin
      // Every live entry climbs to level 3 until the lowest level is invalid.
      write_mode(MODE_QUEUE);
      for (int i = 0; i < 30 && !halt_m; i++) begin
        send_event(OP_SET_QUEUE, 16'hFFFF);
        if (!halt_m) send_event(OP_YIELD, 16'h0);
      end
    end else begin
      write_mode(MODE_RR);
      for (int i = 0; i < 10 && !halt_m; i++) send_event(OP_EXIT, 16'h0);
    end
    send_event(OP_YIELD, 16'h0);
    send_event(OP_SET_PRIO, 16'h1234);
    send_event(OP_TICK, 16'h0);
  endtask

  // ---- checking -----------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (grant_expect_q.size() == 0) begin
        $display("%0t: unexpected grant beat, expected none, actual %p", $time, out_data);
        n_errors++;
      end else begin
        out_item_t e;
        e = grant_expect_q.pop_front();
        if (out_data.grant_id !== e.grant_id) begin
          $display("%0t: grant_id expected %0d actual %0d", $time, e.grant_id,
                   out_data.grant_id);
          n_errors++;
        end
        if (out_data.halted !== e.halted) begin
          $display("%0t: halted expected %0d actual %0d", $time, e.halted, out_data.halted);
          n_errors++;
        end
        if (out_data.error_code !== e.error_code) begin
          $display("%0t: error_code expected %0d actual %0d", $time, e.error_code,
                   out_data.error_code);
          n_errors++;
        end
        n_grants++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < N; i++) begin
      ent_state[i] = (i == 0) ? ST_EMPTY : ST_RUN;
      ent_prio[i]  = '0;
      ent_share[i] = '0;
      ent_runs[i]  = (i == 1) ? 8'd1 : 8'd0;
      ent_queue[i] = (i == 0) ? 2'd0 : 2'((i - 1) & 1);
    end
    cur_id = 1; halt_m = 0; halt_code = ERR_NONE; mode_m = MODE_RR;
    quiet = 0; halt_phase = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_each_mode();
    write_mode(MODE_TOP);
    test_random(1950);
    test_halt();
    drain();
    repeat (60) @(posedge clk);
    $display("Covered %0d events and %0d mode writes across all eight mode codes,",
             n_events, n_cfg);
    $display("checked %0d grant beats, ending in a halt with error code %0d.",
             n_grants, halt_code);
    if (n_errors == 0 && grant_expect_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
